// ----- design/mf2d_pkg.sv -----
// mf2d_pkg: shared types and constants of the 2-D RGBA median filter.
// No dependencies.
`timescale 1ns / 1ps

package mf2d_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned PIX_W  = 32;
    localparam int unsigned HALF_W = 2;
    localparam int unsigned DIM_W  = 11;
    localparam int unsigned IDX_W  = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_HALF   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    // opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [CH_W-1:0]  red_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  blue_in;
        logic [CH_W-1:0]  alpha_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]  red_out;
        logic [CH_W-1:0]  green_out;
        logic [CH_W-1:0]  blue_out;
        logic [CH_W-1:0]  alpha_out;
        logic             frame_last;
    } t_out_item;

    // control between sequencer and selection unit
    typedef struct packed {
        logic clear;   // start a new window
        logic sample;  // sample data valid this cycle
        logic plane;   // run one bit-plane step
    } t_sel_ctrl;

endpackage

// ----- design/mf2d_in_if.sv -----
// mf2d_in_if: valid/ready input channel carrying one input item.
// Depends on mf2d_pkg.
`timescale 1ns / 1ps

interface mf2d_in_if;
    logic               valid;
    logic               ready;
    mf2d_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/mf2d_out_if.sv -----
// mf2d_out_if: valid/ready output channel carrying one result item.
// Depends on mf2d_pkg.
`timescale 1ns / 1ps

interface mf2d_out_if;
    logic                valid;
    logic                ready;
    mf2d_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/mf2d_select.sv -----
// mf2d_select: bit-plane median selection over a window buffer, 4 channels.
// Depends on mf2d_pkg.
`timescale 1ns / 1ps

module mf2d_select #(
    parameter int unsigned MAX_N = 49
) (
    input  logic                            i_clk,
    input  mf2d_pkg::t_sel_ctrl             i_ctrl,
    input  logic [mf2d_pkg::PIX_W-1:0]      i_pix,
    input  logic [$clog2(MAX_N+1)-1:0]      i_rank,
    output logic [mf2d_pkg::PIX_W-1:0]      o_med
);
    localparam int unsigned NW = $clog2(MAX_N + 1);
    localparam int unsigned CW = mf2d_pkg::CH_W;
    localparam int unsigned BW = $clog2(CW);

    logic [mf2d_pkg::PIX_W-1:0] r_buf [MAX_N];
    logic [MAX_N-1:0]           r_used;
    logic [NW-1:0]              r_wr;
    logic [NW-1:0]              r_k   [4];
    logic [MAX_N-1:0]           r_cand[4];
    logic [CW-1:0]              r_res [4];
    logic [BW-1:0]              r_bit;

    // sample buffer: taps written in order
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_wr   <= '0;
            r_used <= '0;
        end else if (i_ctrl.sample) begin
            r_buf[r_wr[$clog2(MAX_N)-1:0]]  <= i_pix;
            r_used[r_wr[$clog2(MAX_N)-1:0]] <= 1'b1;
            r_wr <= r_wr + 1'b1;
        end
    end

    // one bit plane per step, MSB first; r_k is rank among candidates
    always_ff @(posedge i_clk) begin
        logic [MAX_N-1:0] zeros;
        logic [NW-1:0]    nz;
        if (i_ctrl.clear) begin
            r_bit <= BW'(CW - 1);
            for (int c = 0; c < 4; c++) begin
                r_cand[c] <= '1;
                r_k[c]    <= '0;
            end
        end else if (i_ctrl.plane) begin
            r_bit <= r_bit - 1'b1;
            for (int c = 0; c < 4; c++) begin
                zeros = '0;
                for (int i = 0; i < MAX_N; i++)
                    zeros[i] = r_cand[c][i] & r_used[i]
                               & ~r_buf[i][c*CW + int'(r_bit)];
                nz = NW'($countones(zeros));
                if (((r_bit == BW'(CW - 1)) ? i_rank : r_k[c]) < nz) begin
                    r_cand[c] <= (r_cand[c] & r_used) & zeros;
                    r_res[c][r_bit] <= 1'b0;
                    r_k[c] <= (r_bit == BW'(CW - 1)) ? i_rank : r_k[c];
                end else begin
                    r_cand[c] <= (r_cand[c] & r_used) & ~zeros;
                    r_res[c][r_bit] <= 1'b1;
                    r_k[c] <= ((r_bit == BW'(CW - 1)) ? i_rank : r_k[c]) - nz;
                end
            end
        end
    end

    assign o_med = {r_res[3], r_res[2], r_res[1], r_res[0]};
endmodule

// ----- design/median_filter_2d_rgba_unit.sv -----
// Median filter 2-D RGBA: takes a new item only once it is through with the
// last one. A pixel is written to the ring line store; if the next output's
// window is complete, the sequencer reads it one sample per cycle
// ((x1-x0+1)*(y1-y0+1) reads, at most 49 with MAX_HALF 3, then a read-latency
// state) and the selection unit then resolves all four channel medians over
// 8 bit-plane steps. An item passes through accept and check when no output
// is due, and otherwise through accept, check, reads, read latency, 8 planes
// and output; the serial store reads and the plane steps set its duration,
// and a stalled receiver adds its wait. The store needs no clearing pass after reset.
// Depends on mf2d_pkg, mf2d_in_if, mf2d_out_if, mf2d_select.
`timescale 1ns / 1ps

module median_filter_2d_rgba_unit #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024,
    parameter int unsigned MAX_HALF   = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mf2d_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [mf2d_pkg::DIM_W-1:0]    i_cfg_data,
    mf2d_in_if.sink                       in_ch,
    mf2d_out_if.source                    out_ch
);
    localparam int unsigned RING  = 2 * MAX_HALF + 2;
    localparam int unsigned SIDE  = 2 * MAX_HALF + 1;
    localparam int unsigned NMAX  = SIDE * SIDE;
    localparam int unsigned NW    = $clog2(NMAX + 1);
    localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CXW   = $clog2(MAX_WIDTH);
    localparam int unsigned RW    = $clog2(RING);
    localparam int unsigned AW    = $clog2(RING * MAX_WIDTH);
    localparam int unsigned DW    = mf2d_pkg::DIM_W;
    localparam int unsigned PW    = mf2d_pkg::PIX_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_READ  = 6'b000100,
        S_LAST  = 6'b001000,
        S_PLANE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [mf2d_pkg::HALF_W-1:0] r_half;
    logic [DW-1:0]               r_fw, r_fh;
    logic [XW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    logic [mf2d_pkg::HALF_W-1:0] k_eff;
    logic          cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_index == mf2d_pkg::REG_HALF
                     || i_cfg_index == mf2d_pkg::REG_WIDTH
                     || i_cfg_index == mf2d_pkg::REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= mf2d_pkg::HALF_W'(1);
            r_fw   <= DW'(1024);
            r_fh   <= DW'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mf2d_pkg::REG_HALF:   r_half <= i_cfg_data[mf2d_pkg::HALF_W-1:0];
                mf2d_pkg::REG_WIDTH:  r_fw <= i_cfg_data;
                mf2d_pkg::REG_HEIGHT: r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        k_eff = (r_half == '0) ? mf2d_pkg::HALF_W'(1)
              : (32'(r_half) > MAX_HALF) ? mf2d_pkg::HALF_W'(MAX_HALF) : r_half;
        w_eff = (r_fw == '0) ? XW'(1)
              : (32'(r_fw) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(r_fw);
        h_eff = (r_fh == '0) ? YW'(1)
              : (32'(r_fh) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(r_fh);
    end

    // position counters; ring row tracked alongside the input row and read row counters
    logic [XW-1:0] r_in_col, r_out_col;
    logic [YW-1:0] r_in_row, r_out_row;
    logic [RW-1:0] r_in_ring;
    logic [XW-1:0] r_x0, r_x1, r_x;
    logic [YW-1:0] r_y1, r_y;
    logic [RW-1:0] r_yring, r_y0ring;
    logic [XW-1:0] need_col;
    logic [YW-1:0] need_row;
    logic          ready_out, frame_done;
    logic [NW-1:0] r_cnt;
    logic [2:0]    r_pl;
    logic          r_rd_vld;
    logic [PW-1:0] r_rd;
    logic [PW-1:0] r_mem [RING*MAX_WIDTH];
    logic          last_px;
    mf2d_pkg::t_out_item out_item;
    logic          r_ovalid;
    mf2d_pkg::t_sel_ctrl sel;
    logic [PW-1:0] med;

    always_comb begin
        need_row = ({1'b0, r_out_row} + YW'(k_eff) > {1'b0, h_eff - 1'b1})
                 ? h_eff - 1'b1 : r_out_row + YW'(k_eff);
        need_col = ({1'b0, r_out_col} + XW'(k_eff) > {1'b0, w_eff - 1'b1})
                 ? w_eff - 1'b1 : r_out_col + XW'(k_eff);
        ready_out = (r_in_row > need_row)
                 || (r_in_row == need_row && r_in_col > need_col);
        frame_done = (r_out_row >= h_eff - 1'b1) && (r_out_col >= w_eff - 1'b1);
        last_px = (r_x == r_x1);
    end

    // ring row of a back step: wrap the ring index down by d
    function automatic logic [RW-1:0] ring_sub(input logic [RW-1:0] r,
                                               input logic [RW-1:0] d);
        logic [RW:0] t;
        t = {1'b0, r} + (RW+1)'(RING) - {1'b0, d};
        return (t >= (RW+1)'(RING)) ? RW'(t - (RW+1)'(RING)) : RW'(t);
    endfunction

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_ch.valid) n_state = S_CHECK;
            S_CHECK: n_state = ready_out ? S_READ : S_IDLE;
            S_READ:  if (last_px && r_y == r_y1) n_state = S_LAST;
            S_LAST:  n_state = S_PLANE;
            S_PLANE: if (r_pl == 3'd7) n_state = S_OUT;
            S_OUT:   if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // store write happens in the accept cycle; address uses ring row
    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready && in_ch.data.opcode == mf2d_pkg::OP_PIXEL
            && r_in_row < h_eff)
            r_mem[AW'(r_in_ring) * AW'(MAX_WIDTH) + AW'(r_in_col[CXW-1:0])]
                <= {in_ch.data.alpha_in, in_ch.data.blue_in,
                    in_ch.data.green_in, in_ch.data.red_in};
        r_rd <= r_mem[AW'(r_yring) * AW'(MAX_WIDTH) + AW'(r_x[CXW-1:0])];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_col <= '0; r_in_row <= '0; r_in_ring <= '0;
            r_out_col <= '0; r_out_row <= '0;
            r_rd_vld <= 1'b0; r_ovalid <= 1'b0;
            r_cnt <= '0; r_pl <= '0;
        end else begin
            r_rd_vld <= (r_state == S_READ);
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.data.opcode == mf2d_pkg::OP_PIXEL && r_in_row < h_eff) begin
                    if (r_in_col + 1'b1 >= w_eff) begin
                        r_in_col  <= '0;
                        r_in_row  <= r_in_row + 1'b1;
                        r_in_ring <= (r_in_ring == RW'(RING - 1)) ? '0 : r_in_ring + 1'b1;
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
            end
            if (r_state == S_CHECK && ready_out) begin
                r_x0 <= (r_out_col >= XW'(k_eff)) ? r_out_col - XW'(k_eff) : '0;
                r_x  <= (r_out_col >= XW'(k_eff)) ? r_out_col - XW'(k_eff) : '0;
                r_x1 <= need_col;
                r_y1 <= need_row;
                r_y  <= (r_out_row >= YW'(k_eff)) ? r_out_row - YW'(k_eff) : '0;
                // ring row of y0: in_ring is ring(in_row); step back
                r_yring <= ring_sub(r_in_ring, RW'(r_in_row - ((r_out_row >= YW'(k_eff))
                           ? r_out_row - YW'(k_eff) : '0)));
                r_cnt <= '0;
            end
            if (r_state == S_READ) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_px) begin
                    r_x <= r_x0;
                    r_y <= r_y + 1'b1;
                    r_yring <= (r_yring == RW'(RING - 1)) ? '0 : r_yring + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            if (r_state == S_LAST) r_pl <= '0;
            if (r_state == S_PLANE) r_pl <= r_pl + 1'b1;
            if (r_state == S_PLANE && r_pl == 3'd7) begin
                r_ovalid <= 1'b1;
                if (frame_done) begin
                    r_in_col <= '0; r_in_row <= '0; r_in_ring <= '0;
                    r_out_col <= '0; r_out_row <= '0;
                end else if (r_out_col + 1'b1 >= w_eff) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 1'b1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // output register, filled when the medians settle
    logic r_last_q;
    always_ff @(posedge i_clk) begin
        if (r_state == S_PLANE && r_pl == 3'd7) r_last_q <= frame_done;
    end
    assign out_item = '{red_out: med[7:0], green_out: med[15:8],
                        blue_out: med[23:16], alpha_out: med[31:24],
                        frame_last: r_last_q};
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = out_item;

    assign sel.clear  = (r_state == S_CHECK);
    assign sel.sample = r_rd_vld;
    assign sel.plane  = (r_state == S_PLANE);

    mf2d_select #(.MAX_N(NMAX)) u_sel (
        .i_clk (i_clk),
        .i_ctrl(sel),
        .i_pix (r_rd),
        .i_rank(r_cnt >> 1),
        .o_med (med)
    );

    // no new transfer outside the idle state, so none while a result waits
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_cnt < NW'(NMAX))) else $error("window overflow");
    a_valid_after_planes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLANE && r_pl == 3'd7 && !cfg_hit) |=> out_ch.valid)
        else $error("result missing");
endmodule

// ----- bench/tb_median_filter_2d_rgba_unit.sv -----
// tb_median_filter_2d_rgba_unit: self-checking bench for the 2-D RGBA median filter.
// Depends on mf2d_pkg, mf2d_in_if, mf2d_out_if and median_filter_2d_rgba_unit.
`timescale 1ns / 1ps

module tb_median_filter_2d_rgba_unit;

    localparam int unsigned MAXW = 1024;
    localparam int unsigned MAXH = 1024;
    localparam int unsigned MAXK = 3;
    localparam int unsigned RING = 2 * MAXK + 2;
    localparam int unsigned NSMP = (2 * MAXK + 1) * (2 * MAXK + 1);
    localparam int unsigned SETTLE = 120;
    localparam int          ITEMS = 1750;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_DRN} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [7:0]                      r, g, b, a;
        bit                              typed;
        mf2d_pkg::t_out_item             res;
        logic [mf2d_pkg::HALF_W-1:0]     k;
        logic [mf2d_pkg::DIM_W-1:0]      w, h;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [mf2d_pkg::IDX_W-1:0] i_cfg_index;
    logic [mf2d_pkg::DIM_W-1:0] i_cfg_data;

    mf2d_in_if  in_ch ();
    mf2d_out_if out_ch ();

    median_filter_2d_rgba_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source)
    );

    // shadow of the filter state
    logic [31:0]                 pix_store [RING * MAXW];
    int unsigned                 wr_col, wr_row, rd_col, rd_row;
    logic [mf2d_pkg::HALF_W-1:0] sh_half;
    logic [mf2d_pkg::DIM_W-1:0]  sh_width, sh_height;

    mf2d_pkg::t_out_item medians_q [$];
    int        n_fail;
    bit        rx_hold_req;
    int        items_sent;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int unsigned clamp_dim(logic [mf2d_pkg::DIM_W-1:0] v,
                                              int unsigned mx);
        if (v == 0) return 1;
        return (v > mx) ? mx : v;
    endfunction

    // window median of the next owed pixel; returns 1 when one leaves
    function automatic bit median_step(input mf2d_pkg::t_in_item it,
                                       output mf2d_pkg::t_out_item res);
        int unsigned k, w, h, nr, nc, y0, x0, n;
        logic [7:0]  smp [4][NSMP];
        logic [7:0]  v;
        logic [31:0] px;
        int          j;
        k = (sh_half == 0) ? 1 : sh_half;
        w = clamp_dim(sh_width, MAXW);
        h = clamp_dim(sh_height, MAXH);
        res = '0;
        if (it.opcode == mf2d_pkg::OP_PIXEL && wr_row < h) begin
            pix_store[(wr_row % RING) * MAXW + wr_col] =
                {it.alpha_in, it.blue_in, it.green_in, it.red_in};
            wr_col++;
            if (wr_col >= w) begin
                wr_col = 0;
                wr_row++;
            end
        end
        nr = (rd_row + k > h - 1) ? h - 1 : rd_row + k;
        nc = (rd_col + k > w - 1) ? w - 1 : rd_col + k;
        if (!(wr_row > nr || (wr_row == nr && wr_col > nc))) return 0;
        y0 = (rd_row >= k) ? rd_row - k : 0;
        x0 = (rd_col >= k) ? rd_col - k : 0;
        n = 0;
        for (int unsigned y = y0; y <= nr; y++)
            for (int unsigned x = x0; x <= nc; x++) begin
                px = pix_store[(y % RING) * MAXW + x];
                for (int c = 0; c < 4; c++) smp[c][n] = px[8*c +: 8];
                n++;
            end
        // per-channel insertion sort
        for (int c = 0; c < 4; c++)
            for (int i = 1; i < n; i++) begin
                v = smp[c][i];
                j = i;
                while (j > 0 && smp[c][j-1] > v) begin
                    smp[c][j] = smp[c][j-1];
                    j--;
                end
                smp[c][j] = v;
            end
        res.red_out   = smp[0][n/2];
        res.green_out = smp[1][n/2];
        res.blue_out  = smp[2][n/2];
        res.alpha_out = smp[3][n/2];
        res.frame_last = (rd_row >= h - 1) && (rd_col >= w - 1);
        if (res.frame_last) begin
            wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
        end else begin
            rd_col++;
            if (rd_col >= w) begin
                rd_col = 0;
                rd_row++;
            end
        end
        return 1;
    endfunction

    // one item transfer; valid stays high so back-to-back items need no gap
    task automatic send_item(input mf2d_pkg::t_in_item it, input bit typed,
                             input mf2d_pkg::t_out_item texp);
        int unsigned         gap;
        mf2d_pkg::t_out_item res;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
        if (median_step(it, res)) medians_q.insert(medians_q.size(), typed ? texp : res);
        items_sent++;
    endtask

    task automatic send_pix(logic [7:0] r, g, b, a);
        mf2d_pkg::t_in_item it;
        it = '{mf2d_pkg::OP_PIXEL, r, g, b, a};
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_rand_pix();
        send_pix(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_drain();
        mf2d_pkg::t_in_item it;
        it = '{mf2d_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom)};
        send_item(it, 1'b0, '0);
    endtask

    // drop valid and wait until every owed result is back
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (medians_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [mf2d_pkg::IDX_W-1:0] idx,
                             logic [mf2d_pkg::DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            mf2d_pkg::REG_HALF:   sh_half   = val[mf2d_pkg::HALF_W-1:0];
            mf2d_pkg::REG_WIDTH:  sh_width  = val;
            mf2d_pkg::REG_HEIGHT: sh_height = val;
            default: ;
        endcase
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
    endtask

    task automatic set_frame(logic [mf2d_pkg::HALF_W-1:0] k,
                             logic [mf2d_pkg::DIM_W-1:0] w, h);
        wait_drained();
        write_reg(mf2d_pkg::REG_HALF, mf2d_pkg::DIM_W'(k));
        write_reg(mf2d_pkg::REG_WIDTH, w);
        write_reg(mf2d_pkg::REG_HEIGHT, h);
    endtask

    // one frame with stray drains; cut short now and then to test a restart
    task automatic run_frame(bit may_cut);
        int unsigned npix, cut;
        npix = clamp_dim(sh_width, MAXW) * clamp_dim(sh_height, MAXH);
        cut  = (may_cut && $urandom_range(0, 9) == 0) ? $urandom_range(0, npix) : npix;
        for (int unsigned i = 0; i < cut; i++) begin
            if ($urandom_range(0, 9) == 0) send_drain();
            send_rand_pix();
        end
        if (cut != npix) return;
        while (wr_row != 0 || wr_col != 0 || rd_row != 0 || rd_col != 0) begin
            // late pixels are dropped but still move the output along
            if ($urandom_range(0, 7) == 0) send_rand_pix();
            else send_drain();
        end
    endtask

    // receiver with random stalls and one long hold on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                out_ch.ready = 1'b0;
                repeat (3000) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            out_ch.ready = (pick_gap() == 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        mf2d_pkg::t_out_item e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (medians_q.size() == 0) begin
                $error("unexpected result %h", out_ch.data);
                n_fail++;
            end else begin
                e = medians_q.pop_front();
                if (out_ch.data.red_out !== e.red_out) begin
                    $error("red_out exp %h got %h", e.red_out, out_ch.data.red_out);
                    n_fail++;
                end
                if (out_ch.data.green_out !== e.green_out) begin
                    $error("green_out exp %h got %h", e.green_out, out_ch.data.green_out);
                    n_fail++;
                end
                if (out_ch.data.blue_out !== e.blue_out) begin
                    $error("blue_out exp %h got %h", e.blue_out, out_ch.data.blue_out);
                    n_fail++;
                end
                if (out_ch.data.alpha_out !== e.alpha_out) begin
                    $error("alpha_out exp %h got %h", e.alpha_out, out_ch.data.alpha_out);
                    n_fail++;
                end
                if (out_ch.data.frame_last !== e.frame_last) begin
                    $error("frame_last exp %b got %b", e.frame_last, out_ch.data.frame_last);
                    n_fail++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_row               tbl [$];
        mf2d_pkg::t_in_item it;
        n_fail = 0;
        items_sent = 0;
        rx_hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = mf2d_pkg::REG_HALF;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        sh_half = 2'd1;
        sh_width = 11'd1024;
        sh_height = 11'd1024;
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
        for (int i = 0; i < RING * MAXW; i++) pix_store[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single pixel frames pass through, then small borders
        tbl = '{
            '{ROW_CFG, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0, 2'd0, 11'd1, 11'd1},
            '{ROW_PIX, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
              '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
              '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h5A, 8'hA5, 8'h0F, 8'hF0, 1'b1,
              '{8'h5A, 8'hA5, 8'h0F, 8'hF0, 1'b1}, 2'd0, 11'd0, 11'd0},
            '{ROW_DRN, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_CFG, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0, 2'd1, 11'd2, 11'd1},
            '{ROW_DRN, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h10, 8'hF0, 8'h30, 8'h00, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h80, 8'h20, 8'hFF, 8'h01, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h77, 8'h77, 8'h77, 8'h77, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_CFG, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0, 2'd3, 11'd3, 11'd3},
            '{ROW_PIX, 8'h01, 8'h09, 8'h05, 8'hFF, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h02, 8'h08, 8'h05, 8'h00, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h03, 8'h07, 8'h05, 8'hFF, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_DRN, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h04, 8'h06, 8'h05, 8'h00, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h05, 8'h05, 8'h05, 8'hFF, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h06, 8'h04, 8'h05, 8'h00, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h07, 8'h03, 8'h05, 8'hFF, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h08, 8'h02, 8'h05, 8'h00, 1'b0, '0, 2'd0, 11'd0, 11'd0},
            '{ROW_PIX, 8'h09, 8'h01, 8'h05, 8'hFF, 1'b0, '0, 2'd0, 11'd0, 11'd0}
        };
        foreach (tbl[i]) begin
            case (tbl[i].kind)
                ROW_CFG: set_frame(tbl[i].k, tbl[i].w, tbl[i].h);
                ROW_PIX: begin
                    it = '{mf2d_pkg::OP_PIXEL, tbl[i].r, tbl[i].g, tbl[i].b, tbl[i].a};
                    send_item(it, tbl[i].typed, tbl[i].res);
                end
                default: send_drain();
            endcase
        end
        while (wr_row != 0 || wr_col != 0 || rd_row != 0 || rd_col != 0) send_drain();

        // extreme frame shapes: oversized width saturates, zero size acts as one
        set_frame(2'd3, 11'd2047, 11'd1);
        run_frame(1'b0);
        set_frame(2'd2, 11'd0, 11'd0);
        run_frame(1'b0);
        // a narrow tall frame fills the block under a long receiver hold
        set_frame(2'd1, 11'd3, 11'd40);
        rx_hold_req = 1'b1;
        run_frame(1'b0);

        // random frames, mostly small
        while (items_sent < ITEMS) begin
            set_frame(2'($urandom_range(0, 3)),
                      11'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(1, 12)),
                      11'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 30)
                                                       : $urandom_range(1, 9)));
            run_frame(1'b1);
        end

        wait_drained();
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/mf2d_pkg.sv
design/mf2d_in_if.sv
design/mf2d_out_if.sv
design/mf2d_select.sv
design/median_filter_2d_rgba_unit.sv
bench/tb_median_filter_2d_rgba_unit.sv
